// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of this block (tte_checker).
// Depends on nothing; each macro takes its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ----- sv/tte_pkg.sv -----
// Package of the text two-operand evaluator: word types, operator and status
// codes, controller/datapath command types and character helpers. No dependencies.
`default_nettype none

package tte_pkg;

  localparam int OPERAND_WIDTH = 31;
  localparam int VALUE_WIDTH   = 63;
  localparam int ACC_WIDTH     = OPERAND_WIDTH + 4;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

  localparam logic [OPERAND_WIDTH-1:0] OPERAND_MAX = '1;

  // ASCII codes the block reacts to
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_code_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DIV_ZERO = 2'd1,
    STS_NO_OP    = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [1:0]                    status;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic take_char;   // fold the input character into the operand state
    logic eval_start;  // register product, seed divider
    logic div_step;    // one restoring-divide iteration
    logic out_load;    // load output register and clear expression state
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed;  // operator is / or % with a nonzero divisor
    logic div_last;    // current divide iteration is the final one
    logic out_free;    // output register can take a word this cycle
  } dp_sts_t;

  function automatic op_code_e op_of(input logic [7:0] c);
    op_code_e op;
    unique case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_PCT:   op = OP_MOD;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

  // acc * 10 + digit, saturating at the operand maximum
  function automatic logic [OPERAND_WIDTH-1:0] accumulate(
    input logic [OPERAND_WIDTH-1:0] acc,
    input logic [3:0]               digit
  );
    logic [ACC_WIDTH-1:0] wide;
    logic [ACC_WIDTH-1:0] sum;
    wide = ACC_WIDTH'(acc);
    sum  = (wide << 3) + (wide << 1) + ACC_WIDTH'(digit);
    if (sum > ACC_WIDTH'(OPERAND_MAX)) begin
      return OPERAND_MAX;
    end else begin
      return sum[OPERAND_WIDTH-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/tte_ctrl.sv -----
// Controller of the text two-operand evaluator: sequences character intake,
// evaluation, bit-serial divide and result hand-off. Depends on tte_pkg.
`default_nettype none

module tte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             end_of_text_i,
  output logic             in_stall_o,
  input  tte_pkg::dp_sts_t sts_i,
  output tte_pkg::dp_cmd_t cmd_o
);
  import tte_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        in_take;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.take_char  = in_take;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take && end_of_text_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval_start = 1'b1;
        state_d          = sts_i.div_needed ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tte_dpath.sv -----
// Datapath of the text two-operand evaluator: operand accumulation, product
// register, restoring divider, result select and output register. Depends on tte_pkg.
`default_nettype none

module tte_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tte_pkg::in_word_t  in_word_i,
  input  tte_pkg::dp_cmd_t   cmd_i,
  output tte_pkg::dp_sts_t   sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output tte_pkg::out_word_t out_word_o
);
  import tte_pkg::*;

  logic [OPERAND_WIDTH-1:0] first_q, first_d;
  logic [OPERAND_WIDTH-1:0] second_q, second_d;
  op_code_e                 op_q, op_d;
  logic                     first_taken_q, first_taken_d;
  logic                     in_run_q, in_run_d;

  logic [PROD_WIDTH-1:0]    prod_q;
  logic [OPERAND_WIDTH-1:0] rem_q, quo_q;
  logic [CNT_WIDTH-1:0]     cnt_q;

  logic                     out_valid_q;
  out_word_t                out_word_q;

  logic                     is_digit;
  logic [7:0]               digit_full;
  op_code_e                 char_op;

  // Character decode
  assign is_digit   = (in_word_i.char_code >= CH_ZERO) && (in_word_i.char_code <= CH_NINE);
  assign digit_full = in_word_i.char_code - CH_ZERO;
  assign char_op    = op_of(in_word_i.char_code);

  // Operand state update for one character
  always_comb begin
    first_d       = first_q;
    second_d      = second_q;
    op_d          = op_q;
    first_taken_d = first_taken_q;
    in_run_d      = in_run_q;
    if (cmd_i.take_char) begin
      if (is_digit) begin
        if (!first_taken_q) begin
          first_d = accumulate(first_q, digit_full[3:0]);
        end else begin
          // a new run restarts the second operand from zero
          second_d = accumulate(in_run_q ? second_q : '0, digit_full[3:0]);
        end
        in_run_d = 1'b1;
      end else begin
        if (in_run_q) first_taken_d = 1'b1;
        in_run_d = 1'b0;
        if (char_op != OP_NONE) op_d = char_op;
      end
    end
    if (cmd_i.out_load) begin
      first_d       = '0;
      second_d      = '0;
      op_d          = OP_NONE;
      first_taken_d = 1'b0;
      in_run_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q       <= '0;
      second_q      <= '0;
      op_q          <= OP_NONE;
      first_taken_q <= 1'b0;
      in_run_q      <= 1'b0;
    end else begin
      first_q       <= first_d;
      second_q      <= second_d;
      op_q          <= op_d;
      first_taken_q <= first_taken_d;
      in_run_q      <= in_run_d;
    end
  end

  // Restoring divider, one quotient bit per step
  logic [OPERAND_WIDTH:0]   trial;
  logic                     trial_ge;
  logic [OPERAND_WIDTH:0]   trial_diff;

  assign trial      = {rem_q, quo_q[OPERAND_WIDTH-1]};
  assign trial_ge   = trial >= {1'b0, second_q};
  assign trial_diff = trial - {1'b0, second_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      prod_q <= PROD_WIDTH'(first_q) * PROD_WIDTH'(second_q);
      rem_q  <= '0;
      quo_q  <= first_q;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
      quo_q <= {quo_q[OPERAND_WIDTH-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.eval_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Result select
  logic [VALUE_WIDTH-1:0] res_value;
  status_e                res_status;

  always_comb begin
    res_value  = '0;
    res_status = STS_OK;
    case (op_q)
      OP_ADD: res_value = VALUE_WIDTH'(first_q) + VALUE_WIDTH'(second_q);
      OP_SUB: res_value = VALUE_WIDTH'(first_q) - VALUE_WIDTH'(second_q);
      OP_MUL: res_value = VALUE_WIDTH'(prod_q);
      OP_DIV: begin
        if (second_q == '0) res_status = STS_DIV_ZERO;
        else                res_value  = VALUE_WIDTH'(quo_q);
      end
      OP_MOD: begin
        if (second_q == '0) res_status = STS_DIV_ZERO;
        else                res_value  = VALUE_WIDTH'(rem_q);
      end
      default: res_status = STS_NO_OP;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q.value  <= res_value;
      out_word_q.status <= res_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_word_o       = out_word_q;

  assign sts_o.div_needed = ((op_q == OP_DIV) || (op_q == OP_MOD)) && (second_q != '0);
  assign sts_o.div_last   = (cnt_q == CNT_WIDTH'(OPERAND_WIDTH - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ----- sv/text_two_operand_evaluator.sv -----
// Text two-operand evaluator, top level: joins the controller and the datapath.
// Depends on tte_pkg, tte_ctrl and tte_dpath.
//
// Takes an expression as ASCII words, one character per word, and returns one
// result word (value and status) after the word flagged end_of_text. Ordinary
// characters are taken one per cycle. The final character passes through the
// steps intake, evaluate and output load for + - * and for no operator; / and %
// with a nonzero divisor add the bit-serial restoring divider between evaluate
// and output load. Input is stalled from the final character until its result
// is in the output register; a result word waiting there does not block further
// characters, only the next evaluation. Operand state clears when the result is
// loaded.
`default_nettype none

module text_two_operand_evaluator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tte_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tte_pkg::out_word_t out_word_o
);
  import tte_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tte_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_text_i (in_word_i.end_of_text),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tte_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- sv/tte_checker.sv -----
// Port-level checker for the text two-operand evaluator, bound to the top level.
// Depends on tte_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input tte_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tte_pkg::out_word_t out_word_o
);
  import tte_pkg::*;

  logic last_acc;
  logic held;
  logic status_known;
  logic err_word;

  // Port conditions the properties refer to
  assign last_acc     = in_valid_i && !in_stall_o && in_word_i.end_of_text;
  assign held         = out_valid_o && out_stall_i;
  assign status_known = (out_word_o.status == STS_OK) || (out_word_o.status == STS_DIV_ZERO) ||
                        (out_word_o.status == STS_NO_OP);
  assign err_word     = out_valid_o && (out_word_o.status != STS_OK) &&
                        (out_word_o.value != '0);

  // Status is always one of the defined codes
  `ASSERT_PROP(a_status_code, clk_i, rst_ni, out_valid_o |-> status_known, "undefined status code")

  // Error results carry a zero value
  `ASSERT_NEVER(a_err_zero, clk_i, rst_ni, err_word, "nonzero value with error status")

  // Final character makes the block busy for evaluation
  `ASSERT_PROP(a_end_busy, clk_i, rst_ni, last_acc |=> in_stall_o, "no stall after final character")

  // Stalled result word stays valid and unchanged
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, held |=> out_valid_o, "result word dropped while stalled")
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni, held |=> $stable(out_word_o), "result word changed")

endmodule

bind text_two_operand_evaluator tte_checker u_checker (.*);

`default_nettype wire
